// File: rtl/core/i2cbs_pkg.sv
// Package for the I2C controller bit sequencer.
// Holds command codes, phase codes and the item structs; no dependencies.
`default_nettype none

package i2cbs_pkg;

    localparam int PHASE_W = 5;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_BEGIN = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_STOP  = 3'd4;

    localparam logic [PHASE_W-1:0] PH_START_SDA  = 5'd0;
    localparam logic [PHASE_W-1:0] PH_START_SCL  = 5'd1;
    localparam logic [PHASE_W-1:0] PH_BIT_SET    = 5'd2;
    localparam logic [PHASE_W-1:0] PH_BIT_RISE   = 5'd3;
    localparam logic [PHASE_W-1:0] PH_BIT_SAMPLE = 5'd4;
    localparam logic [PHASE_W-1:0] PH_BIT_FALL   = 5'd5;
    localparam logic [PHASE_W-1:0] PH_ACK_SET    = 5'd6;
    localparam logic [PHASE_W-1:0] PH_ACK_RISE   = 5'd7;
    localparam logic [PHASE_W-1:0] PH_ACK_SAMPLE = 5'd8;
    localparam logic [PHASE_W-1:0] PH_ACK_FALL   = 5'd9;
    localparam logic [PHASE_W-1:0] PH_FINISH     = 5'd10;
    localparam logic [PHASE_W-1:0] PH_STOP_SDA   = 5'd11;
    localparam logic [PHASE_W-1:0] PH_STOP_RISE  = 5'd12;
    localparam logic [PHASE_W-1:0] PH_STOP_END   = 5'd13;
    localparam logic [PHASE_W-1:0] PH_RS_SDA     = 5'd14;
    localparam logic [PHASE_W-1:0] PH_RS_SCL     = 5'd15;

    localparam logic [2:0] LAST_BIT = 3'd7;

    // Input transaction, first field in the highest bits.
    typedef struct packed {
        logic       sda_in;
        logic       scl_in;
        logic [7:0] write_byte;
        logic       direction;
        logic [6:0] target_address;
        logic [2:0] mode;
    } in_item_t;

    // Result transaction, first field in the highest bits.
    typedef struct packed {
        logic       busy_res;
        logic [7:0] read_data;
        logic       nack;
        logic       done_res;
        logic       scl_drive_low;
        logic       sda_drive_low;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/i2c_controller_bit_sequencer.sv
// Top level of the I2C controller bit sequencer (controller side only).
// Depends on i2cbs_pkg for codes and item structs.
//
//  Channel | Dir | Ports                  | Payload
//  s_      | in  | s_tvalid/tready/tdata  | command or tick with line samples
//  m_      | out | m_tvalid/tready/tdata  | line drives, done, nack, data, busy
//
// The input register is followed by the phase update into the result
// register. One transaction per cycle sustained; each stage holds only while
// the stage after it is full and not taken. aresetn clears control and
// sequencer state: lines released, idle, no session open.
`default_nettype none

module i2c_controller_bit_sequencer (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // mode[2:0], target_address[9:3], direction[10], write_byte[18:11],
    // scl_in[19], sda_in[20], zero[23:21]
    input  wire  [23:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // sda_drive_low[0], scl_drive_low[1], done_res[2], nack[3],
    // read_data[11:4], busy_res[12], zero[15:13]
    output logic [15:0] m_tdata
);
    import i2cbs_pkg::*;

    logic           in_valid_reg;
    in_item_t       in_item_reg;
    logic           out_valid_reg;
    out_item_t      out_item_reg;
    logic           adv_in;
    logic           adv_out;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [2:0]     bit_index_reg, bit_index_next;
    logic           reading_reg, reading_next;
    logic [7:0]     shift_byte_reg, shift_byte_next;
    logic           ack_status_reg, ack_status_next;
    logic           running_reg, running_next;
    logic           session_open_reg, session_open_next;
    logic           sda_low_reg, sda_low_next;
    logic           scl_low_reg, scl_low_next;
    logic           done;
    logic           is_cmd;

    assign adv_out  = in_valid_reg && (!out_valid_reg || m_tready);
    assign adv_in   = !in_valid_reg || adv_out;
    assign s_tready = adv_in;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_item_reg};

    assign is_cmd = !running_reg && (in_item_reg.mode >= MODE_BEGIN)
                    && (in_item_reg.mode <= MODE_STOP);

    always_comb begin
        phase_next        = phase_reg;
        bit_index_next    = bit_index_reg;
        reading_next      = reading_reg;
        shift_byte_next   = shift_byte_reg;
        ack_status_next   = ack_status_reg;
        running_next      = running_reg;
        session_open_next = session_open_reg;
        sda_low_next      = sda_low_reg;
        scl_low_next      = scl_low_reg;
        done              = 1'b0;

        if (is_cmd) begin
            case (in_item_reg.mode)
                MODE_BEGIN: begin
                    shift_byte_next   = {in_item_reg.target_address, in_item_reg.direction};
                    reading_next      = 1'b0;
                    bit_index_next    = '0;
                    ack_status_next   = 1'b0;
                    running_next      = 1'b1;
                    phase_next        = session_open_reg ? PH_RS_SDA : PH_START_SDA;
                    session_open_next = 1'b1;
                end
                MODE_WRITE: begin
                    shift_byte_next   = in_item_reg.write_byte;
                    reading_next      = 1'b0;
                    bit_index_next    = '0;
                    ack_status_next   = 1'b0;
                    running_next      = 1'b1;
                    phase_next        = PH_START_SDA;
                    session_open_next = 1'b1;
                end
                MODE_READ: begin
                    shift_byte_next   = '0;
                    reading_next      = 1'b1;
                    bit_index_next    = '0;
                    ack_status_next   = 1'b0;
                    running_next      = 1'b1;
                    phase_next        = PH_BIT_SET;
                    session_open_next = 1'b1;
                end
                default: begin
                    if (session_open_reg) begin
                        running_next = 1'b1;
                        phase_next   = PH_STOP_SDA;
                    end else begin
                        done = 1'b1;
                    end
                end
            endcase
        end else if (running_reg) begin
            case (phase_reg)
                PH_START_SDA: begin
                    sda_low_next = 1'b1;
                    phase_next   = PH_START_SCL;
                end
                PH_START_SCL: begin
                    scl_low_next = 1'b1;
                    phase_next   = PH_BIT_SET;
                end
                PH_BIT_SET: begin
                    if (!reading_reg) begin
                        sda_low_next    = !shift_byte_reg[7];
                        shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                    end
                    phase_next = PH_BIT_RISE;
                end
                PH_BIT_RISE: begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_BIT_SAMPLE;
                end
                PH_BIT_SAMPLE: begin
                    if (in_item_reg.scl_in) begin
                        if (reading_reg) begin
                            shift_byte_next = {shift_byte_reg[6:0], in_item_reg.sda_in};
                        end
                        phase_next = PH_BIT_FALL;
                    end
                end
                PH_BIT_FALL: begin
                    sda_low_next = 1'b0;
                    scl_low_next = 1'b1;
                    if (bit_index_reg != LAST_BIT) begin
                        bit_index_next = bit_index_reg + 3'd1;
                        phase_next     = PH_BIT_SET;
                    end else begin
                        phase_next = PH_ACK_SET;
                    end
                end
                PH_ACK_SET: begin
                    if (reading_reg) begin
                        sda_low_next = 1'b1;
                    end
                    phase_next = PH_ACK_RISE;
                end
                PH_ACK_RISE: begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_ACK_SAMPLE;
                end
                PH_ACK_SAMPLE: begin
                    if (in_item_reg.scl_in) begin
                        if (!reading_reg) begin
                            ack_status_next = in_item_reg.sda_in;
                        end
                        phase_next = PH_ACK_FALL;
                    end
                end
                PH_ACK_FALL: begin
                    scl_low_next = 1'b1;
                    phase_next   = PH_FINISH;
                end
                PH_FINISH: begin
                    if (reading_reg) begin
                        sda_low_next = 1'b0;
                    end
                    running_next = 1'b0;
                    phase_next   = PH_START_SDA;
                    done         = 1'b1;
                end
                PH_STOP_SDA: begin
                    sda_low_next = 1'b1;
                    phase_next   = PH_STOP_RISE;
                end
                PH_STOP_RISE: begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_STOP_END;
                end
                PH_STOP_END: begin
                    if (in_item_reg.scl_in) begin
                        sda_low_next      = 1'b0;
                        running_next      = 1'b0;
                        session_open_next = 1'b0;
                        phase_next        = PH_START_SDA;
                        done              = 1'b1;
                    end
                end
                PH_RS_SDA: begin
                    sda_low_next = 1'b0;
                    phase_next   = PH_RS_SCL;
                end
                PH_RS_SCL: begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_START_SDA;
                end
                default: begin
                    running_next = 1'b0;
                    phase_next   = PH_START_SDA;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= '0;
            bit_index_reg    <= '0;
            reading_reg      <= 1'b0;
            shift_byte_reg   <= '0;
            ack_status_reg   <= 1'b0;
            running_reg      <= 1'b0;
            session_open_reg <= 1'b0;
            sda_low_reg      <= 1'b0;
            scl_low_reg      <= 1'b0;
        end else begin
            if (adv_in) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv_out) begin
                out_valid_reg    <= 1'b1;
                phase_reg        <= phase_next;
                bit_index_reg    <= bit_index_next;
                reading_reg      <= reading_next;
                shift_byte_reg   <= shift_byte_next;
                ack_status_reg   <= ack_status_next;
                running_reg      <= running_next;
                session_open_reg <= session_open_next;
                sda_low_reg      <= sda_low_next;
                scl_low_reg      <= scl_low_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_in && s_tvalid) begin
            in_item_reg <= in_item_t'(s_tdata[20:0]);
        end
        if (adv_out) begin
            out_item_reg.sda_drive_low <= sda_low_next;
            out_item_reg.scl_drive_low <= scl_low_next;
            out_item_reg.done_res      <= done;
            out_item_reg.nack          <= ack_status_next;
            out_item_reg.read_data     <= reading_next ? shift_byte_next : 8'h00;
            out_item_reg.busy_res      <= running_next;
        end
    end

endmodule

`default_nettype wire
